FILE: sv/mwj_pkg.sv
// Package for the Manhattan walk join checker.
// Holds the item types, status codes and walker control struct.
// No dependencies.
package mwj_pkg;

  localparam int WALK_FIELD_W = 30;
  localparam int KEY_FIELD_W  = 20;
  localparam int COUNT_W      = 32;
  localparam int STATUS_W     = 2;

  // Status codes of a result item
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_JOIN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TURN   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd3;

  // Command codes of an input item
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [WALK_FIELD_W-1:0] walk_bits;
  } mwj_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [KEY_FIELD_W-1:0] prefix_key;
    logic [KEY_FIELD_W-1:0] end_key;
    logic [COUNT_W-1:0]     join_count;
  } mwj_out_t;

  typedef struct packed {
    logic init;
    logic adv;
  } mwj_walk_ctl_t;

endpackage

FILE: sv/manhattan_walk_join_checker_unit.sv
// Manhattan walk join checker, top level. Depends on mwj_pkg, mwj_walker
// and mwj_cell.
//
// Assert start with an item while busy is low. A load item traces its walk
// one step per cycle into a chain of WALK_STEPS+1 point cells; a test item
// first checks the turn pattern at the join and, if that passes, traces its
// walk one step per cycle from the prefix end while every cell compares its
// stored point with the current point. Load and passing test items hold busy
// while the single walker steps once per cycle through the walk; no new item
// is taken until its trace ends. A turn reject returns its result in the
// cycle after it is taken. Each item gives one result, shown for one cycle
// with out_valid high; the receiver cannot stall it. A new item may be
// taken during that cycle.
// Test items before the first load read undefined prefix points.
module manhattan_walk_join_checker_unit
  import mwj_pkg::*;
#(
  parameter int WALK_STEPS = 30,
  parameter int KEY_STEPS  = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mwj_in_t  in_item,
  output logic     out_valid,
  output mwj_out_t out_item
);

  localparam int KEY_LEN = (KEY_STEPS > WALK_STEPS) ? WALK_STEPS : KEY_STEPS;
  localparam int KEY_X_W = (KEY_LEN > KEY_FIELD_W) ? KEY_LEN : KEY_FIELD_W;
  localparam int COORD_W = $clog2(2 * WALK_STEPS + 1) + 1;
  localparam int PT_W    = 2 * COORD_W;
  localparam int NCELL   = WALK_STEPS + 1;
  localparam int CNT_W   = $clog2(WALK_STEPS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_TEST
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   hit_r, hit_nxt;
  logic [WALK_STEPS-1:0]  prefix_walk_r, prefix_walk_nxt;
  logic [PT_W-1:0]        prefix_end_r, prefix_end_nxt;
  logic [COUNT_W-1:0]     join_cnt_r, join_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [KEY_LEN-1:0]     sfx_key_r, sfx_key_nxt;
  logic [KEY_FIELD_W-1:0] out_end_key_r, out_end_key_nxt;

  logic                   accept;
  logic [WALK_STEPS-1:0]  walk_ext;
  logic                   turns;
  logic [KEY_LEN-1:0]     sfx_key;
  logic                   last_step;
  logic                   match_any;
  logic [KEY_X_W-1:0]     end_key_x;
  logic [KEY_X_W-1:0]     prefix_key_x;
  mwj_walk_ctl_t          walk_ctl;
  logic [PT_W-1:0]        init_pt;
  logic [PT_W-1:0]        cur_pt;
  logic [PT_W-1:0]        chain [NCELL+1];
  logic [NCELL-1:0]       match_vec;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign walk_ext = WALK_STEPS'(in_item.walk_bits);

  // Turn test across the join: last two prefix steps and first two suffix steps
  always_comb begin
    logic a, b, c, d;
    a = prefix_walk_r[1];
    b = prefix_walk_r[0];
    c = walk_ext[WALK_STEPS-1];
    d = walk_ext[WALK_STEPS-2];
    turns = ((a == c) && (b != a)) || ((b == d) && (c != b));
  end

  // Bin key of the suffix: last steps, complemented when the lead bit is set
  assign sfx_key = walk_ext[KEY_LEN-1] ? ~walk_ext[KEY_LEN-1:0] : walk_ext[KEY_LEN-1:0];

  assign last_step = (cnt_r == CNT_W'(WALK_STEPS));

  // Walker control: start a trace on an accepted load or passing test, step through load and test
  always_comb begin
    walk_ctl.init = accept && ((in_item.command == CMD_LOAD) || !turns);
    walk_ctl.adv  = (state_r == S_LOAD) || (state_r == S_TEST);
    init_pt       = (in_item.command == CMD_LOAD) ? '0 : prefix_end_r;
  end

  mwj_walker #(
    .WALK_STEPS(WALK_STEPS),
    .COORD_W   (COORD_W)
  ) u_walker (
    .clk      (clk),
    .ctl      (walk_ctl),
    .init_pt  (init_pt),
    .init_walk(walk_ext),
    .pt       (cur_pt)
  );

  // Point chain: walker feeds the head, each cell compares with the walker
  assign chain[0] = cur_pt;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mwj_cell #(
      .PT_W(PT_W)
    ) u_cell (
      .clk     (clk),
      .shift_en(state_r == S_LOAD),
      .pt_in   (chain[i]),
      .probe   (cur_pt),
      .pt_out  (chain[i+1]),
      .match   (match_vec[i])
    );
  end

  assign match_any = |match_vec;

  // Widen the held suffix key to the output field
  assign end_key_x = KEY_X_W'(sfx_key_r);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    hit_nxt         = hit_r;
    prefix_walk_nxt = prefix_walk_r;
    prefix_end_nxt  = prefix_end_r;
    join_cnt_nxt    = join_cnt_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    sfx_key_nxt     = sfx_key_r;
    out_end_key_nxt = out_end_key_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          hit_nxt = 1'b0;
          if (in_item.command == CMD_LOAD) begin
            prefix_walk_nxt = walk_ext;
            state_nxt       = S_LOAD;
          end else if (turns) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_TURN;
            out_end_key_nxt = '0;
          end else begin
            sfx_key_nxt = sfx_key;
            state_nxt   = S_TEST;
          end
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) begin
          prefix_end_nxt  = cur_pt;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_LOADED;
          out_end_key_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      S_TEST: begin
        // Compare every point after the first step; the prefix end is skipped
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          hit_nxt = hit_r || match_any;
        end
        if (last_step) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (hit_r || match_any) begin
            out_status_nxt  = ST_HIT;
            out_end_key_nxt = '0;
          end else begin
            out_status_nxt  = ST_JOIN;
            out_end_key_nxt = end_key_x[KEY_FIELD_W-1:0];
            if (join_cnt_r != '1) begin
              join_cnt_nxt = join_cnt_r + COUNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      hit_r         <= 1'b0;
      prefix_walk_r <= '0;
      prefix_end_r  <= '0;
      join_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
      out_status_r  <= ST_LOADED;
      out_end_key_r <= '0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      hit_r         <= hit_nxt;
      prefix_walk_r <= prefix_walk_nxt;
      prefix_end_r  <= prefix_end_nxt;
      join_cnt_r    <= join_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
      out_end_key_r <= out_end_key_nxt;
    end
    sfx_key_r <= sfx_key_nxt;
  end

  // Drive the result item; key and count registers hold through the strobe
  assign prefix_key_x = KEY_X_W'(prefix_walk_r[WALK_STEPS-1 -: KEY_LEN]);

  assign out_valid           = out_valid_r;
  assign out_item.status     = out_status_r;
  assign out_item.prefix_key = prefix_key_x[KEY_FIELD_W-1:0];
  assign out_item.end_key    = out_end_key_r;
  assign out_item.join_count = join_cnt_r;

endmodule

FILE: sv/mwj_cell.sv
// One cell of the prefix point chain: holds one visited point.
// Shifts its point on to the next cell and compares it with the probe point.
// Depends on nothing.
module mwj_cell #(
  parameter int PT_W = 14
) (
  input  logic            clk,
  input  logic            shift_en,
  input  logic [PT_W-1:0] pt_in,
  input  logic [PT_W-1:0] probe,
  output logic [PT_W-1:0] pt_out,
  output logic            match
);

  logic [PT_W-1:0] pt_r;

  // Take the neighbor's point while the chain fills
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pt_r <= pt_in;
    end
  end

  assign pt_out = pt_r;

  // Flag a collision with the walker's current point
  assign match = (pt_r == probe);

endmodule

FILE: sv/mwj_walker.sv
// Walk tracer: holds the current lattice point and the remaining step bits.
// Takes one Manhattan-lattice step per advance. Uses mwj_pkg.
module mwj_walker
  import mwj_pkg::*;
#(
  parameter int WALK_STEPS = 30,
  parameter int COORD_W    = 7
) (
  input  logic                 clk,
  input  mwj_walk_ctl_t        ctl,
  input  logic [2*COORD_W-1:0] init_pt,
  input  logic [WALK_STEPS-1:0] init_walk,
  output logic [2*COORD_W-1:0] pt
);

  logic [COORD_W-1:0]    x_r, x_nxt;
  logic [COORD_W-1:0]    y_r, y_nxt;
  logic [WALK_STEPS-1:0] walk_r, walk_nxt;
  logic                  step_bit;

  assign step_bit = walk_r[WALK_STEPS-1];

  // Load on init, else step: vertical by x parity, horizontal by y parity
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    walk_nxt = walk_r;
    if (ctl.init) begin
      x_nxt    = init_pt[2*COORD_W-1:COORD_W];
      y_nxt    = init_pt[COORD_W-1:0];
      walk_nxt = init_walk;
    end else if (ctl.adv) begin
      walk_nxt = {walk_r[WALK_STEPS-2:0], 1'b0};
      if (!step_bit) begin
        y_nxt = x_r[0] ? (y_r - COORD_W'(1)) : (y_r + COORD_W'(1));
      end else begin
        x_nxt = y_r[0] ? (x_r - COORD_W'(1)) : (x_r + COORD_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    walk_r <= walk_nxt;
  end

  assign pt = {x_r, y_r};

endmodule

FILE: sv/mwj_checker.sv
// Port-level checks for the Manhattan walk join checker.
// Depends on mwj_pkg; bound to manhattan_walk_join_checker_unit below.
module mwj_checker
  import mwj_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input mwj_out_t out_item
);

  // An accepted item either starts a trace or returns its reject at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither traced nor answered");

  // A load result only follows a trace
  a_load_after_trace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_LOADED)) |-> $past(busy))
    else $error("load result without a trace");

  // A valid join has been counted
  a_join_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_JOIN)) |-> (out_item.join_count != '0))
    else $error("valid join with zero count");

  // Only a valid join carries a bin key
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_JOIN)) |-> (out_item.end_key == '0))
    else $error("end key set on a non-join result");

endmodule

bind manhattan_walk_join_checker_unit mwj_checker u_mwj_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);
